// File: rtl/bezier_subsegment_extract_unit_defines.svh
// Assertion macros for the curve piece extractor.
`ifndef BEZIER_SUBSEGMENT_EXTRACT_UNIT_DEFINES_SVH
`define BEZIER_SUBSEGMENT_EXTRACT_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/bse_pkg.sv
// ---------------------------------------------------------------------------
// bse_pkg
// Shared constants of the curve piece extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package bse_pkg;
	localparam int COORD_BITS_DEF      = 24;
	localparam int PARAM_FRAC_BITS_DEF = 16;
endpackage

// File: rtl/bse_divider.sv
// ---------------------------------------------------------------------------
// bse_divider
// Pipelined restoring divider: one quotient bit per stage, saturated to 1.0, zero for a zero divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bse_divider import bse_pkg::*; #(
	parameter int FB = PARAM_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [FB:0]   num,
	input  logic [FB:0]   den,
	output logic [FB:0]   quo
);
	localparam int QB = 2 * FB + 1;
	localparam int RB = FB + 2;
	logic [QB-1:0] q_s  [1:QB];
	logic [FB:0]   r_s  [1:QB-1];
	logic [FB:0]   d_s  [1:QB-1];
	logic          z_s  [1:QB];

	// The dividend shifts left into the remainder, one bit per stage.
	for (genvar i = 0; i < QB; i++) begin : g_st
		logic [QB-1:0] qi;
		logic [FB:0]   ri;
		logic [FB:0]   di;
		logic          zi;
		logic [RB-1:0] rs;
		logic          ge;
		if (i == 0) begin : g_first
			assign qi = {num, {FB{1'b0}}};
			assign ri = '0;
			assign di = den;
			assign zi = (den == '0);
		end else begin : g_next
			assign qi = q_s[i];
			assign ri = r_s[i];
			assign di = d_s[i];
			assign zi = z_s[i];
		end
		assign rs = {ri, qi[QB-1]};
		assign ge = (rs >= {1'b0, di});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				z_s[i+1] <= 1'b0;
			end else if (en) begin
				z_s[i+1] <= zi;
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				q_s[i+1] <= {qi[QB-2:0], ge};
		end
		if (i < QB - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					d_s[i+1] <= di;
					r_s[i+1] <= ge ? (FB+1)'(rs - {1'b0, di}) : (FB+1)'(rs);
				end
			end
		end
	end

	always_comb begin
		if (z_s[QB])
			quo = '0;
		else if (q_s[QB] > QB'(1 << FB))
			quo = (FB+1)'(1 << FB);
		else
			quo = q_s[QB][FB:0];
	end
endmodule

// File: rtl/bse_lerp.sv
// ---------------------------------------------------------------------------
// bse_lerp
// Registered rounded interpolation u + round((v - u) * t).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module bse_lerp import bse_pkg::*; #(
	parameter int CB = COORD_BITS_DEF,
	parameter int FB = PARAM_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CB-1:0] u,
	input  logic signed [CB-1:0] v,
	input  logic        [FB:0]   t,
	output logic signed [CB-1:0] r
);
	localparam int PB = CB + FB + 3;
	logic signed [CB:0]   dif;
	logic signed [PB-1:0] prod;
	logic signed [PB-1:0] q;
	always_comb begin
		dif  = (CB+1)'(v) - (CB+1)'(u);
		prod = PB'(dif) * $signed({1'b0, t}) + PB'(1 << (FB - 1));
		q    = prod >>> FB;
	end
	always_ff @(posedge clk) begin
		if (en)
			r <= CB'(u + q[CB-1:0]);
	end
endmodule

// File: rtl/bezier_subsegment_extract_unit.sv
// ---------------------------------------------------------------------------
// bezier_subsegment_extract_unit
// Extracts the piece of a cubic Bezier curve between two curve parameters.
// ---------------------------------------------------------------------------
// Channel | Direction | Contents
// s_axis  | in        | four control points, from_param, to_param
// m_axis  | out       | four control points of the piece
//
// One item is accepted per cycle while the output is not stalled. Each item
// passes the first split, the bit-serial divider stages and the second
// split. Reset clears only the valid bits and the divider's zero-divisor flags.
// When the output is stalled the whole pipeline holds; nothing is lost or repeated.
`timescale 1ns / 1ps
module bezier_subsegment_extract_unit import bse_pkg::*; #(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, finish_x, finish_y,
	// from_param, to_param (low bits first, zero padded to bytes)
	input  logic [((8*COORD_BITS+2*PARAM_FRAC_BITS+2+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// piece_start_x/y, piece_ctrl1_x/y, piece_ctrl2_x/y, piece_finish_x/y
	output logic [((8*COORD_BITS+7)/8)*8-1:0] m_axis_tdata
);
	`include "bezier_subsegment_extract_unit_defines.svh"
	localparam int CB  = COORD_BITS;
	localparam int FB  = PARAM_FRAC_BITS;
	localparam int DL  = 2 * FB + 1;
	localparam int LAT = 3 + DL + 3;
	localparam int PW  = FB + 1;
	localparam logic [PW-1:0] ONE = PW'(1 << FB);

	// Pipeline advances whenever the output register is free or drained.
	logic en;
	logic [LAT-1:0] vld_q;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
	end

	// Input unpack and parameter saturation.
	logic signed [CB-1:0] cx [4];
	logic signed [CB-1:0] cy [4];
	logic [PW-1:0] a_in, b_in, a_sat, b_sat;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cx[k] = s_axis_tdata[2*k*CB +: CB];
			cy[k] = s_axis_tdata[(2*k+1)*CB +: CB];
		end
		a_in  = s_axis_tdata[8*CB +: PW];
		b_in  = s_axis_tdata[8*CB+PW +: PW];
		a_sat = (a_in > ONE) ? ONE : a_in;
		b_sat = (b_in > ONE) ? ONE : b_in;
	end

	// Stage-by-stage carried values of the first split.
	logic signed [CB-1:0] p0x_s1, p0y_s1, p3x_s1, p3y_s1;
	logic signed [CB-1:0] p0x_s2, p0y_s2, p3x_s2, p3y_s2, l01x_s2, l01y_s2;
	logic signed [CB-1:0] l23x_s2, l23y_s2;
	logic signed [CB-1:0] a01x_s1, a01y_s1, a12x_s1, a12y_s1, a23x_s1, a23y_s1;
	logic signed [CB-1:0] b012x_s2, b012y_s2, b123x_s2, b123y_s2;
	logic signed [CB-1:0] c0123x_s3, c0123y_s3;
	logic [PW-1:0] a_s1, a_s2, b_s1, b_s2;
	logic rise_s1, rise_s2;

	// First level of the split at a.
	for (genvar k = 0; k < 3; k++) begin : g_l1
		logic signed [CB-1:0] rx, ry;
		bse_lerp #(.CB(CB), .FB(FB)) u_x (.clk(clk), .en(en), .u(cx[k]), .v(cx[k+1]),
			.t(a_sat), .r(rx));
		bse_lerp #(.CB(CB), .FB(FB)) u_y (.clk(clk), .en(en), .u(cy[k]), .v(cy[k+1]),
			.t(a_sat), .r(ry));
		if (k == 0) begin : g0
			assign a01x_s1 = rx; assign a01y_s1 = ry;
		end else if (k == 1) begin : g1
			assign a12x_s1 = rx; assign a12y_s1 = ry;
		end else begin : g2
			assign a23x_s1 = rx; assign a23y_s1 = ry;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p0x_s1 <= cx[0]; p0y_s1 <= cy[0];
			p3x_s1 <= cx[3]; p3y_s1 <= cy[3];
			a_s1 <= a_sat; b_s1 <= b_sat;
			rise_s1 <= a_sat < b_sat;
		end
	end

	bse_lerp #(.CB(CB), .FB(FB)) u_b012x (.clk(clk), .en(en), .u(a01x_s1), .v(a12x_s1),
		.t(a_s1), .r(b012x_s2));
	bse_lerp #(.CB(CB), .FB(FB)) u_b012y (.clk(clk), .en(en), .u(a01y_s1), .v(a12y_s1),
		.t(a_s1), .r(b012y_s2));
	bse_lerp #(.CB(CB), .FB(FB)) u_b123x (.clk(clk), .en(en), .u(a12x_s1), .v(a23x_s1),
		.t(a_s1), .r(b123x_s2));
	bse_lerp #(.CB(CB), .FB(FB)) u_b123y (.clk(clk), .en(en), .u(a12y_s1), .v(a23y_s1),
		.t(a_s1), .r(b123y_s2));
	always_ff @(posedge clk) begin
		if (en) begin
			p0x_s2 <= p0x_s1; p0y_s2 <= p0y_s1;
			p3x_s2 <= p3x_s1; p3y_s2 <= p3y_s1;
			l01x_s2 <= a01x_s1; l01y_s2 <= a01y_s1;
			l23x_s2 <= a23x_s1; l23y_s2 <= a23y_s1;
			a_s2 <= a_s1; b_s2 <= b_s1; rise_s2 <= rise_s1;
		end
	end

	bse_lerp #(.CB(CB), .FB(FB)) u_c0123x (.clk(clk), .en(en), .u(b012x_s2), .v(b123x_s2),
		.t(a_s2), .r(c0123x_s3));
	bse_lerp #(.CB(CB), .FB(FB)) u_c0123y (.clk(clk), .en(en), .u(b012y_s2), .v(b123y_s2),
		.t(a_s2), .r(c0123y_s3));

	// Half kept after the first split, held in order q0..q3.
	logic signed [CB-1:0] hx_s3 [4];
	logic signed [CB-1:0] hy_s3 [4];
	logic rise_s3;
	logic [PW-1:0] num_s3, den_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rise_s3 <= rise_s2;
			if (rise_s2) begin
				hx_s3[1] <= b123x_s2; hy_s3[1] <= b123y_s2;
				hx_s3[2] <= l23x_s2;  hy_s3[2] <= l23y_s2;
				hx_s3[3] <= p3x_s2;   hy_s3[3] <= p3y_s2;
				num_s3 <= b_s2 - a_s2;
				den_s3 <= ONE - a_s2;
			end else begin
				hx_s3[0] <= p0x_s2;   hy_s3[0] <= p0y_s2;
				hx_s3[1] <= l01x_s2;  hy_s3[1] <= l01y_s2;
				hx_s3[2] <= b012x_s2; hy_s3[2] <= b012y_s2;
				num_s3 <= b_s2;
				den_s3 <= a_s2;
			end
		end
	end
	// Point 0 (rising) or point 3 (falling) is the split point itself.
	logic signed [CB-1:0] qx [4];
	logic signed [CB-1:0] qy [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qx[k] = hx_s3[k]; qy[k] = hy_s3[k];
		end
		if (rise_s3) begin
			qx[0] = c0123x_s3; qy[0] = c0123y_s3;
		end else begin
			qx[3] = c0123x_s3; qy[3] = c0123y_s3;
		end
	end

	// Ratio division; points travel alongside in a delay line.
	logic [PW-1:0] r_d;
	bse_divider #(.FB(FB)) u_div (.clk(clk), .arst_n(arst_n), .en(en),
		.num(num_s3), .den(den_s3), .quo(r_d));
	logic signed [CB-1:0] dx_q [1:DL][4];
	logic signed [CB-1:0] dy_q [1:DL][4];
	logic                 dr_q [1:DL];
	always_ff @(posedge clk) begin
		if (en) begin
			dx_q[1] <= qx; dy_q[1] <= qy; dr_q[1] <= rise_s3;
		end
	end
	for (genvar i = 1; i < DL; i++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				dx_q[i+1] <= dx_q[i]; dy_q[i+1] <= dy_q[i]; dr_q[i+1] <= dr_q[i];
			end
		end
	end

	// Second split at the ratio.
	logic signed [CB-1:0] ex [4];
	logic signed [CB-1:0] ey [4];
	assign ex = dx_q[DL];
	assign ey = dy_q[DL];
	logic signed [CB-1:0] e01x_s4, e01y_s4, e12x_s4, e12y_s4, e23x_s4, e23y_s4;
	logic signed [CB-1:0] f012x_s5, f012y_s5, f123x_s5, f123y_s5;
	logic signed [CB-1:0] g0123x_s6, g0123y_s6;
	logic signed [CB-1:0] e0x_s4, e0y_s4, e3x_s4, e3y_s4;
	logic signed [CB-1:0] e0x_s5, e0y_s5, e3x_s5, e3y_s5, e01x_s5, e01y_s5, e23x_s5, e23y_s5;
	logic [PW-1:0] r_s4, r_s5;
	logic rise_s4, rise_s5;

	bse_lerp #(.CB(CB), .FB(FB)) u_e01x (.clk(clk), .en(en), .u(ex[0]), .v(ex[1]),
		.t(r_d), .r(e01x_s4));
	bse_lerp #(.CB(CB), .FB(FB)) u_e01y (.clk(clk), .en(en), .u(ey[0]), .v(ey[1]),
		.t(r_d), .r(e01y_s4));
	bse_lerp #(.CB(CB), .FB(FB)) u_e12x (.clk(clk), .en(en), .u(ex[1]), .v(ex[2]),
		.t(r_d), .r(e12x_s4));
	bse_lerp #(.CB(CB), .FB(FB)) u_e12y (.clk(clk), .en(en), .u(ey[1]), .v(ey[2]),
		.t(r_d), .r(e12y_s4));
	bse_lerp #(.CB(CB), .FB(FB)) u_e23x (.clk(clk), .en(en), .u(ex[2]), .v(ex[3]),
		.t(r_d), .r(e23x_s4));
	bse_lerp #(.CB(CB), .FB(FB)) u_e23y (.clk(clk), .en(en), .u(ey[2]), .v(ey[3]),
		.t(r_d), .r(e23y_s4));
	always_ff @(posedge clk) begin
		if (en) begin
			e0x_s4 <= ex[0]; e0y_s4 <= ey[0]; e3x_s4 <= ex[3]; e3y_s4 <= ey[3];
			r_s4 <= r_d; rise_s4 <= dr_q[DL];
		end
	end
	bse_lerp #(.CB(CB), .FB(FB)) u_f012x (.clk(clk), .en(en), .u(e01x_s4), .v(e12x_s4),
		.t(r_s4), .r(f012x_s5));
	bse_lerp #(.CB(CB), .FB(FB)) u_f012y (.clk(clk), .en(en), .u(e01y_s4), .v(e12y_s4),
		.t(r_s4), .r(f012y_s5));
	bse_lerp #(.CB(CB), .FB(FB)) u_f123x (.clk(clk), .en(en), .u(e12x_s4), .v(e23x_s4),
		.t(r_s4), .r(f123x_s5));
	bse_lerp #(.CB(CB), .FB(FB)) u_f123y (.clk(clk), .en(en), .u(e12y_s4), .v(e23y_s4),
		.t(r_s4), .r(f123y_s5));
	always_ff @(posedge clk) begin
		if (en) begin
			e0x_s5 <= e0x_s4; e0y_s5 <= e0y_s4; e3x_s5 <= e3x_s4; e3y_s5 <= e3y_s4;
			e01x_s5 <= e01x_s4; e01y_s5 <= e01y_s4;
			e23x_s5 <= e23x_s4; e23y_s5 <= e23y_s4;
			r_s5 <= r_s4; rise_s5 <= rise_s4;
		end
	end
	bse_lerp #(.CB(CB), .FB(FB)) u_g0123x (.clk(clk), .en(en), .u(f012x_s5), .v(f123x_s5),
		.t(r_s5), .r(g0123x_s6));
	bse_lerp #(.CB(CB), .FB(FB)) u_g0123y (.clk(clk), .en(en), .u(f012y_s5), .v(f123y_s5),
		.t(r_s5), .r(g0123y_s6));

	// Rising: lower half (e0, e01, f012, g). Falling: upper half reversed
	// (e3, e23, f123, g).
	logic signed [CB-1:0] ox_s6 [3];
	logic signed [CB-1:0] oy_s6 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			if (rise_s5) begin
				ox_s6[0] <= e0x_s5;   oy_s6[0] <= e0y_s5;
				ox_s6[1] <= e01x_s5;  oy_s6[1] <= e01y_s5;
				ox_s6[2] <= f012x_s5; oy_s6[2] <= f012y_s5;
			end else begin
				ox_s6[0] <= e3x_s5;   oy_s6[0] <= e3y_s5;
				ox_s6[1] <= e23x_s5;  oy_s6[1] <= e23y_s5;
				ox_s6[2] <= f123x_s5; oy_s6[2] <= f123y_s5;
			end
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int k = 0; k < 3; k++) begin
			m_axis_tdata[2*k*CB +: CB]     = ox_s6[k];
			m_axis_tdata[(2*k+1)*CB +: CB] = oy_s6[k];
		end
		m_axis_tdata[6*CB +: CB] = g0123x_s6;
		m_axis_tdata[7*CB +: CB] = g0123y_s6;
	end

	`BSE_ASSERT_IMPL(a_ready_when_free, clk, arst_n, !m_axis_tvalid, s_axis_tready, "ready low while output empty")
	`BSE_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(vld_q), "pipeline moved while stalled")
	`BSE_ASSERT_NEXT(a_ratio_sat, clk, arst_n, vld_q[3+DL-1] && en, r_s4 <= ONE, "ratio above one")
endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Checks the curve piece extractor against a bit-exact model of de Casteljau
// subdivision: directed corner items, random curves under idle patterns, then a long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import bse_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int PF = PARAM_FRAC_BITS_DEF;
	localparam int IN_W = ((8*CB+2*PF+2+7)/8)*8;
	localparam int OUT_W = ((8*CB+7)/8)*8;
	localparam int LATENCY = 3 + (2*PF+1) + 3;
	localparam longint ONE = 64'd1 << PF;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [CB-1:0] px [4];
		logic signed [CB-1:0] py [4];
		logic [PF:0] from_p;
		logic [PF:0] to_p;
	} curve_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	// Percent of cycles each side idles; a long receiver stall runs on hold_go.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	logic hold_active = 1'b0;
	event hold_go;
	int errors = 0;
	longint cycles = 0;
	logic [OUT_W-1:0] expected_pieces [$];

	bezier_subsegment_extract_unit i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bezier_subsegment_extract_unit test failed");
			$finish;
		end
	end

	// Rounded interpolation between u and v at parameter t.
	function automatic longint lerp(longint u, longint v, longint t);
		longint p;
		p = (v - u) * t + (64'sd1 <<< (PF - 1));
		return u + (p >>> PF);
	endfunction

	// Splits the curve (x,y) at t into lower and upper halves.
	function automatic void split_at(input longint x [4], input longint y [4],
			input longint t, output longint lx [4], output longint ly [4],
			output longint hx [4], output longint hy [4]);
		longint ax01, ay01, ax12, ay12, ax23, ay23, ax012, ay012, ax123, ay123, am_x, am_y;
		ax01 = lerp(x[0], x[1], t); ay01 = lerp(y[0], y[1], t);
		ax12 = lerp(x[1], x[2], t); ay12 = lerp(y[1], y[2], t);
		ax23 = lerp(x[2], x[3], t); ay23 = lerp(y[2], y[3], t);
		ax012 = lerp(ax01, ax12, t); ay012 = lerp(ay01, ay12, t);
		ax123 = lerp(ax12, ax23, t); ay123 = lerp(ay12, ay23, t);
		am_x = lerp(ax012, ax123, t); am_y = lerp(ay012, ay123, t);
		lx = '{x[0], ax01, ax012, am_x}; ly = '{y[0], ay01, ay012, am_y};
		hx = '{am_x, ax123, ax23, x[3]}; hy = '{am_y, ay123, ay23, y[3]};
	endfunction

	function automatic longint sat_ratio(longint num, longint den);
		longint q;
		if (den == 0)
			return 0;
		q = (num << PF) / den;
		return (q > ONE) ? ONE : q;
	endfunction

	function automatic logic [OUT_W-1:0] extract_piece(curve_t c);
		longint x [4], y [4], lx [4], ly [4], hx [4], hy [4];
		longint l2x [4], l2y [4], h2x [4], h2y [4];
		longint a, b;
		logic [OUT_W-1:0] r;
		r = '0;
		a = c.from_p; b = c.to_p;
		if (a > ONE) a = ONE;
		if (b > ONE) b = ONE;
		for (int k = 0; k < 4; k++) begin
			x[k] = c.px[k]; y[k] = c.py[k];
		end
		split_at(x, y, a, lx, ly, hx, hy);
		if (a < b) begin
			split_at(hx, hy, sat_ratio(b - a, ONE - a), l2x, l2y, h2x, h2y);
		end else begin
			split_at(lx, ly, sat_ratio(b, a), h2x, h2y, l2x, l2y);
			for (int k = 0; k < 4; k++) begin
				x[k] = l2x[3-k]; y[k] = l2y[3-k];
			end
			l2x = x; l2y = y;
		end
		for (int k = 0; k < 4; k++) begin
			r[2*k*CB +: CB] = l2x[k][CB-1:0];
			r[(2*k+1)*CB +: CB] = l2y[k][CB-1:0];
		end
		return r;
	endfunction

	task automatic send_curve(curve_t c);
		logic [IN_W-1:0] d;
		d = '0;
		for (int k = 0; k < 4; k++) begin
			d[2*k*CB +: CB] = c.px[k];
			d[(2*k+1)*CB +: CB] = c.py[k];
		end
		d[8*CB +: PF+1] = c.from_p;
		d[8*CB+PF+1 +: PF+1] = c.to_p;
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tdata <= d;
		s_axis_tvalid <= 1'b1;
		expected_pieces.push_back(extract_piece(c));
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2: return CB'($urandom_range(2047) - 1024);
			default: return CB'($urandom);
		endcase
	endfunction

	function automatic logic [PF:0] rand_param();
		case ($urandom_range(9))
			0: return '0;
			1: return (PF+1)'(ONE);
			2: return '1;
			3: return (PF+1)'(ONE + $urandom_range(int'(ONE - 1)));
			default: return (PF+1)'($urandom_range(int'(ONE)));
		endcase
	endfunction

	function automatic curve_t rand_curve();
		curve_t c;
		for (int k = 0; k < 4; k++) begin
			c.px[k] = rand_coord(); c.py[k] = rand_coord();
		end
		c.from_p = rand_param();
		c.to_p = ($urandom_range(7) == 0) ? c.from_p : rand_param();
		return c;
	endfunction

	// Long receiver stall, counted here while the sender keeps offering items.
	always begin
		@(hold_go);
		hold_active = 1'b1;
		repeat (hold_len) @(posedge clk);
		hold_active = 1'b0;
	end

	// Receiver: stalls at random, honors the long stall, checks every piece.
	always @(posedge clk) begin
		logic [OUT_W-1:0] exp_piece;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pieces.size() == 0) begin
				$error("unexpected piece %h", m_axis_tdata);
				errors++;
			end else begin
				exp_piece = expected_pieces.pop_front();
				for (int f = 0; f < 8; f++)
					if (m_axis_tdata[f*CB +: CB] !== exp_piece[f*CB +: CB]) begin
						$error("field %s: expected %h, actual %h",
							f == 0 ? "piece_start_x" : f == 1 ? "piece_start_y" :
							f == 2 ? "piece_ctrl1_x" : f == 3 ? "piece_ctrl1_y" :
							f == 4 ? "piece_ctrl2_x" : f == 5 ? "piece_ctrl2_y" :
							f == 6 ? "piece_finish_x" : "piece_finish_y",
							exp_piece[f*CB +: CB], m_axis_tdata[f*CB +: CB]);
						errors++;
					end
			end
		end
		if (hold_active)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic test_directed();
		curve_t c;
		logic [PF:0] pairs [12][2];
		pairs = '{'{0, 0}, '{0, ONE}, '{ONE, 0}, '{ONE, ONE}, '{ONE/2, ONE/2},
			'{ONE/4, 3*ONE/4}, '{3*ONE/4, ONE/4}, '{'1, 0}, '{0, '1},
			'{'1, '1}, '{1, ONE-1}, '{ONE-1, 1}};
		foreach (pairs[i]) begin
			for (int k = 0; k < 4; k++) begin
				c.px[k] = (k[0]) ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
				c.py[k] = (k[1]) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
			end
			c.from_p = pairs[i][0];
			c.to_p = pairs[i][1];
			send_curve(c);
			for (int k = 0; k < 4; k++) begin
				c.px[k] = rand_coord(); c.py[k] = rand_coord();
			end
			send_curve(c);
		end
	endtask

	task automatic test_random(int count, int gap, int stall);
		send_gap_pct = gap;
		recv_stall_pct = stall;
		repeat (count) send_curve(rand_curve());
	endtask

	// Holds the output off long enough that the pipeline fills and stalls input.
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_len = 4 * LATENCY;
		-> hold_go;
		repeat (3 * LATENCY) send_curve(rand_curve());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 0, 0);
		test_random(200, 46, 0);
		test_random(200, 0, 46);
		test_random(200, 10, 10);
		test_backpressure();
		s_axis_tvalid <= 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		while (expected_pieces.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("bezier_subsegment_extract_unit test passed");
		else
			$display("bezier_subsegment_extract_unit test failed");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/bse_pkg.sv
rtl/bse_divider.sv
rtl/bse_lerp.sv
rtl/bezier_subsegment_extract_unit.sv
verif/tb.sv
